FILE: rtl/occgrid_pkg.sv
// Shared types and constants for the occupancy grid with time decay.
// No dependencies; imported by occupancy_grid_with_time_decay.
package occgrid_pkg;

    localparam int DEF_CELLS_X = 64;
    localparam int DEF_CELLS_Y = 64;

    localparam logic [15:0] WIDTH_RST  = 16'd3000;
    localparam logic [15:0] HEIGHT_RST = 16'd2000;

    localparam logic [7:0] LEVEL_FULL = 8'd255;
    localparam logic [7:0] OCC_LEVEL  = 8'd25;

    // age / 1000 for age below 2^18 as (age * DECAY_RECIP) >> DECAY_SHIFT
    localparam int MS_PER_S    = 1000;
    localparam int AGE_W       = 18;
    localparam int DECAY_RECIP = 268436;
    localparam int DECAY_SHIFT = 28;
    localparam int PROD_W      = 37;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_DECAY = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [12:0] {
        S_IDLE      = 13'h0001,
        S_CLR       = 13'h0002,
        S_ST_LOAD   = 13'h0004,
        S_ST_DIV    = 13'h0008,
        S_ST_CHK    = 13'h0010,
        S_Q_CHK     = 13'h0020,
        S_ADDR      = 13'h0040,
        S_WR        = 13'h0080,
        S_RD        = 13'h0100,
        S_CMP       = 13'h0200,
        S_DEC_RUN   = 13'h0400,
        S_DEC_DRAIN = 13'h0800,
        S_DONE      = 13'h1000
    } t_state;

endpackage

FILE: rtl/occupancy_grid_with_time_decay.sv
// Occupancy grid of 8-bit levels and 32-bit stamps with store, decay, query, clear.
// Depends on occgrid_pkg for constants, command codes and state encoding.
//
// channel  dir  handshake                    payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tuser=command, tdata=coords,now
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata=occupied,stored
// cfg      in   i_cfg_we                     i_cfg_addr, i_cfg_wdata
//
// Store: one shared restoring divider, one quotient bit per cycle, run for x then y,
//   DW = 16 + clog2(max(CELLS_X,CELLS_Y)+1) quotient bits each (23 at 64x64).
// Decay: one cell per cycle on one memory read port and one write port.
// After reset a clearing pass over all cells runs with o_s_axis_tready low.
// One transaction at a time; a finished result waits in the output register.
module occupancy_grid_with_time_decay
    import occgrid_pkg::*;
#(
    parameter int CELLS_X = DEF_CELLS_X,
    parameter int CELLS_Y = DEF_CELLS_Y
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // world_x[15:0], world_y[31:16], cell_x[47:32], cell_y[63:48], now_ms[95:64]
    input  logic [95:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // occupied[0], stored[1], zero[7:2]
    output logic [7:0]  o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int NCELLS = CELLS_X * CELLS_Y;
    localparam int AW     = $clog2(NCELLS);
    localparam int XW     = $clog2(CELLS_X);
    localparam int YW     = $clog2(CELLS_Y);
    localparam int CMAX   = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
    localparam int DW     = 16 + $clog2(CMAX + 1);
    localparam int CNTW   = $clog2(DW);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NCELLS - 1);

    logic [7:0]  mem_level [NCELLS];
    logic [31:0] mem_stamp [NCELLS];

    t_state r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic r_clr_cmd, n_clr_cmd;
    t_cmd r_cmd, n_cmd;
    logic [15:0] r_wx, n_wx, r_wy, n_wy, r_cx, n_cx, r_cy, n_cy;
    logic [31:0] r_now, n_now;
    logic r_axis, n_axis, r_neg, n_neg;
    logic [DW-1:0] r_num, n_num;
    logic [15:0] r_rem, n_rem, r_den, n_den;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [XW-1:0] r_qx, n_qx;
    logic [YW-1:0] r_qy, n_qy;
    logic r_res_occ, n_res_occ, r_res_sto, n_res_sto;
    logic r_out_valid, n_out_valid, r_out_occ, n_out_occ, r_out_sto, n_out_sto;
    logic [15:0] r_width, r_height;

    logic [7:0]  r_rd_level;
    logic [31:0] r_rd_stamp;

    logic r_p1_v, r_p2_v;
    logic [AW-1:0] r_p1_addr, r_p2_addr;
    logic [PROD_W-1:0] r_p2_prod;
    logic [7:0] r_p2_level;
    logic r_p2_lt, r_p2_apply;

    logic w_in_acc;
    logic w_rd_en, w_dec_rd;
    logic w_we_level, w_we_stamp;
    logic [AW-1:0] w_wr_addr;
    logic [7:0] w_wr_level;
    logic [31:0] w_wr_stamp;

    logic [15:0] w_coord, w_mag, w_size;
    logic [DW-1:0] w_cells;
    logic [16:0] w_trial, w_diff;
    logic w_ge, w_q_ok, w_cx_ok, w_cy_ok;
    logic [AW-1:0] w_addr_calc;

    logic [31:0] w_age;
    logic [AGE_W-1:0] w_lim;
    logic w_lt, w_apply;
    logic [7:0] w_dec, w_new_level;

    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_sto, r_out_occ};

    assign w_coord = r_axis ? r_wy : r_wx;
    assign w_mag   = w_coord[15] ? (16'd0 - w_coord) : w_coord;
    assign w_size  = r_axis ? r_height : r_width;
    assign w_cells = r_axis ? DW'(CELLS_Y) : DW'(CELLS_X);

    assign w_trial = {r_rem, r_num[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_q_ok  = r_neg ? (r_num == '0) : (r_num < w_cells);

    assign w_cx_ok = !r_cx[15] && (r_cx < 16'(CELLS_X));
    assign w_cy_ok = !r_cy[15] && (r_cy < 16'(CELLS_Y));

    assign w_addr_calc = AW'(AW'(r_qx) * AW'(CELLS_Y) + AW'(r_qy));

    assign w_age   = r_now - r_rd_stamp;
    assign w_lim   = AGE_W'(AGE_W'(r_rd_level) * AGE_W'(MS_PER_S));
    assign w_lt    = (w_age < {{(32 - AGE_W){1'b0}}, w_lim});
    assign w_apply = (w_age != 32'd0) && (r_rd_level != 8'd0);

    assign w_dec       = r_p2_prod[DECAY_SHIFT +: 8];
    assign w_new_level = r_p2_lt ? (r_p2_level - w_dec) : 8'd0;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_clr_cmd   = r_clr_cmd;
        n_cmd       = r_cmd;
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_now       = r_now;
        n_axis      = r_axis;
        n_neg       = r_neg;
        n_num       = r_num;
        n_rem       = r_rem;
        n_den       = r_den;
        n_cnt       = r_cnt;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_res_occ   = r_res_occ;
        n_res_sto   = r_res_sto;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_occ   = r_out_occ;
        n_out_sto   = r_out_sto;
        w_rd_en     = 1'b0;
        w_dec_rd    = 1'b0;
        w_we_level  = 1'b0;
        w_we_stamp  = 1'b0;
        w_wr_addr   = r_addr;
        w_wr_level  = 8'd0;
        w_wr_stamp  = 32'd0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd     = t_cmd'(i_s_axis_tuser);
                    n_wx      = i_s_axis_tdata[15:0];
                    n_wy      = i_s_axis_tdata[31:16];
                    n_cx      = i_s_axis_tdata[47:32];
                    n_cy      = i_s_axis_tdata[63:48];
                    n_now     = i_s_axis_tdata[95:64];
                    n_res_occ = 1'b0;
                    n_res_sto = 1'b0;
                    n_axis    = 1'b0;
                    n_addr    = '0;
                    unique case (t_cmd'(i_s_axis_tuser))
                        CMD_STORE: n_state = S_ST_LOAD;
                        CMD_DECAY: n_state = S_DEC_RUN;
                        CMD_QUERY: n_state = S_Q_CHK;
                        CMD_CLEAR: begin
                            n_clr_cmd = 1'b1;
                            n_state   = S_CLR;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CLR: begin
                w_we_level = 1'b1;
                w_we_stamp = 1'b1;
                n_addr     = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end
            end
            S_ST_LOAD: begin
                n_num = DW'(DW'(w_mag) * w_cells);
                n_neg = w_coord[15];
                n_den = w_size;
                n_rem = 16'd0;
                n_cnt = CNTW'(DW - 1);
                n_state = (w_size == 16'd0) ? S_DONE : S_ST_DIV;
            end
            S_ST_DIV: begin
                n_rem = w_ge ? w_diff[15:0] : w_trial[15:0];
                n_num = {r_num[DW-2:0], w_ge};
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    n_state = S_ST_CHK;
                end
            end
            S_ST_CHK: begin
                priority if (!w_q_ok) begin
                    n_state = S_DONE;
                end else if (!r_axis) begin
                    n_qx    = r_num[XW-1:0];
                    n_axis  = 1'b1;
                    n_state = S_ST_LOAD;
                end else begin
                    n_qy    = r_num[YW-1:0];
                    n_state = S_ADDR;
                end
            end
            S_Q_CHK: begin
                if (w_cx_ok && w_cy_ok) begin
                    n_qx    = r_cx[XW-1:0];
                    n_qy    = r_cy[YW-1:0];
                    n_state = S_ADDR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ADDR: begin
                n_addr  = w_addr_calc;
                n_state = (r_cmd == CMD_QUERY) ? S_RD : S_WR;
            end
            S_WR: begin
                w_we_level = 1'b1;
                w_we_stamp = 1'b1;
                w_wr_level = LEVEL_FULL;
                w_wr_stamp = r_now;
                n_res_sto  = 1'b1;
                n_state    = S_DONE;
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_res_occ = (r_rd_level > OCC_LEVEL);
                n_state   = S_DONE;
            end
            S_DEC_RUN: begin
                w_rd_en  = 1'b1;
                w_dec_rd = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DEC_DRAIN;
                end
            end
            S_DEC_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_occ   = r_res_occ;
                    n_out_sto   = r_res_sto;
                    n_clr_cmd   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (r_p2_v && r_p2_apply) begin
            w_we_level = 1'b1;
            w_wr_addr  = r_p2_addr;
            w_wr_level = w_new_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
            r_p1_v      <= w_dec_rd;
            r_p2_v      <= r_p1_v;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_WIDTH:  r_width  <= i_cfg_wdata;
                    CFG_HEIGHT: r_height <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_wx      <= n_wx;
        r_wy      <= n_wy;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_now     <= n_now;
        r_axis    <= n_axis;
        r_neg     <= n_neg;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_cnt     <= n_cnt;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_res_occ <= n_res_occ;
        r_res_sto <= n_res_sto;
        r_out_occ <= n_out_occ;
        r_out_sto <= n_out_sto;
        r_p1_addr <= r_addr;
        r_p2_addr <= r_p1_addr;
        r_p2_level <= r_rd_level;
        r_p2_lt    <= w_lt;
        r_p2_apply <= w_apply;
        r_p2_prod  <= PROD_W'(PROD_W'(w_age[AGE_W-1:0]) * PROD_W'(DECAY_RECIP));
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_level <= mem_level[r_addr];
            r_rd_stamp <= mem_stamp[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_level) begin
            mem_level[w_wr_addr] <= w_wr_level;
        end
        if (w_we_stamp) begin
            mem_stamp[w_wr_addr] <= w_wr_stamp;
        end
    end

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_we_level && !w_we_stamp))
        else $error("memory write while idle");

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DEC_RUN && r_state != S_DEC_DRAIN) |-> (!r_p1_v && !r_p2_v))
        else $error("decay pipeline busy outside decay sweep");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state != S_IDLE))
        else $error("accepted transaction left no work");

    a_stored_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_sto) |-> (r_cmd == CMD_STORE))
        else $error("stored flag on non-store command");
`endif

endmodule
